// File: hw/rtl/jdq_pkg.sv
// Package for the joystick direction qualifier.
// Holds field widths, register indexes, reset values and shared types.
// No dependencies.
package jdq_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int TIME_W     = 32;
    localparam int MS_W       = 16;
    localparam int DIR_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DZ_LOW       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DZ_HIGH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_DEB    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_DEB      = 3'd5;

    // Register values after reset.
    localparam logic [SAMPLE_W-1:0] DZ_LOW_RST     = 12'd1800;
    localparam logic [SAMPLE_W-1:0] DZ_HIGH_RST    = 12'd2300;
    localparam logic [SAMPLE_W-1:0] CENTER_RST     = 12'd2048;
    localparam logic [MS_W-1:0]     LONG_PRESS_RST = 16'd1000;
    localparam logic [MS_W-1:0]     PRESS_DEB_RST  = 16'd50;
    localparam logic [MS_W-1:0]     DIR_DEB_RST    = 16'd200;

    typedef enum logic [DIR_W-1:0] {
        DIR_IDLE  = 3'd0,
        DIR_NORTH = 3'd1,
        DIR_SOUTH = 3'd2,
        DIR_WEST  = 3'd3,
        DIR_EAST  = 3'd4
    } dir_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] x_sample;
        logic [SAMPLE_W-1:0] y_sample;
        logic                button_down;
        logic [TIME_W-1:0]   now_ms;
    } in_item_t;

    typedef struct packed {
        dir_t direction;
        logic reset_request;
        logic mode_toggle_request;
    } out_item_t;

endpackage

// File: hw/rtl/jdq_if.sv
// Valid/ready channel interfaces for the joystick direction qualifier.
// Depends on jdq_pkg for field widths.
interface jdq_in_if;
    logic                         valid;
    logic                         ready;
    logic [jdq_pkg::SAMPLE_W-1:0] x_sample;
    logic [jdq_pkg::SAMPLE_W-1:0] y_sample;
    logic                         button_down;
    logic [jdq_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, output x_sample, output y_sample,
                    output button_down, output now_ms, input ready);
    modport sink   (input valid, input x_sample, input y_sample,
                    input button_down, input now_ms, output ready);
endinterface

interface jdq_out_if;
    logic                      valid;
    logic                      ready;
    logic [jdq_pkg::DIR_W-1:0] direction;
    logic                      reset_request;
    logic                      mode_toggle_request;

    modport source (output valid, output direction, output reset_request,
                    output mode_toggle_request, input ready);
    modport sink   (input valid, input direction, input reset_request,
                    input mode_toggle_request, output ready);
endinterface

// File: hw/rtl/joystick_direction_qualifier_top.sv
// An accepted request is held in the input register, then moves on to the result register.
// Throughput: one request per cycle; the only limit is the result side's ready.
// The input register and the result register each hold one request, so the
// block can take one more request while one finished result waits to be taken.
// Reset (rst_n, asynchronous, active low) empties both registers, clears the
// tracked direction and button state and loads the default configuration.
module joystick_direction_qualifier_top (
    input  logic                           clk,
    input  logic                           rst_n,
    jdq_in_if.sink                         in_ch,
    jdq_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [jdq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jdq_pkg::CFG_DATA_W-1:0] cfg_data
);
    import jdq_pkg::*;

    // Configuration registers.
    logic [SAMPLE_W-1:0] dz_low_reg;
    logic [SAMPLE_W-1:0] dz_high_reg;
    logic [SAMPLE_W-1:0] center_reg;
    logic [MS_W-1:0]     long_press_reg;
    logic [MS_W-1:0]     press_deb_reg;
    logic [MS_W-1:0]     dir_deb_reg;

    // Pipeline registers.
    logic      s1_valid_reg, s1_valid_next;
    in_item_t  s1_item_reg;
    logic      s2_valid_reg, s2_valid_next;
    out_item_t s2_res_reg, s2_res_next;

    // Qualifier state.
    dir_t              tracked_reg, tracked_next;
    logic [TIME_W-1:0] dir_time_reg, dir_time_next;
    logic              held_reg, held_next;
    logic [TIME_W-1:0] press_start_reg, press_start_next;

    // Handshake control.
    logic s2_free;
    logic s1_fire;
    logic in_fire;

    // Per-request logic.
    logic              x_lo, x_hi, y_lo, y_hi;
    logic [SAMPLE_W-1:0] dist_x, dist_y;
    dir_t              cur_dir;
    logic [TIME_W-1:0] press_dur;
    logic [TIME_W-1:0] dir_elapsed;
    logic              press_edge, release_edge;
    logic              dir_report;

    // The result register frees up when it is empty or being emptied. The
    // input register moves on whenever the result register can take its
    // request, so the input side stalls only when both registers are full
    // and the result is not being taken.
    assign s2_free     = !s2_valid_reg || out_ch.ready;
    assign s1_fire     = s1_valid_reg && s2_free;
    assign in_ch.ready = !s1_valid_reg || s2_free;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_fire)
        begin
            s2_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            s2_valid_next = 1'b0;
        end
        else
        begin
            s2_valid_next = s2_valid_reg;
        end
    end

    // Direction classification. A sample inside [low, high] counts as
    // centred; the axis with the larger deflection wins, Y on a tie.
    always_comb
    begin
        x_lo = s1_item_reg.x_sample < dz_low_reg;
        x_hi = s1_item_reg.x_sample > dz_high_reg;
        y_lo = s1_item_reg.y_sample < dz_low_reg;
        y_hi = s1_item_reg.y_sample > dz_high_reg;

        dist_x = (s1_item_reg.x_sample >= center_reg) ?
                 s1_item_reg.x_sample - center_reg : center_reg - s1_item_reg.x_sample;
        dist_y = (s1_item_reg.y_sample >= center_reg) ?
                 s1_item_reg.y_sample - center_reg : center_reg - s1_item_reg.y_sample;

        cur_dir = DIR_IDLE;
        if (!x_lo && !x_hi && !y_lo && !y_hi)
        begin
            cur_dir = DIR_IDLE;
        end
        else if (dist_x > dist_y)
        begin
            if (x_lo)
            begin
                cur_dir = DIR_WEST;
            end
            else if (x_hi)
            begin
                cur_dir = DIR_EAST;
            end
        end
        else
        begin
            if (y_lo)
            begin
                cur_dir = DIR_NORTH;
            end
            else if (y_hi)
            begin
                cur_dir = DIR_SOUTH;
            end
        end
    end

    // Button and direction timing. All time differences wrap modulo 2^32.
    always_comb
    begin
        press_edge   = s1_item_reg.button_down && !held_reg;
        release_edge = !s1_item_reg.button_down && held_reg;
        press_dur    = s1_item_reg.now_ms - press_start_reg;
        dir_elapsed  = s1_item_reg.now_ms - dir_time_reg;

        held_next        = held_reg;
        press_start_next = press_start_reg;
        s2_res_next.reset_request       = 1'b0;
        s2_res_next.mode_toggle_request = 1'b0;
        if (press_edge)
        begin
            held_next        = 1'b1;
            press_start_next = s1_item_reg.now_ms;
        end
        else if (release_edge)
        begin
            held_next = 1'b0;
            // The long press test wins even if its threshold is the lower one.
            if (press_dur >= {{(TIME_W-MS_W){1'b0}}, long_press_reg})
            begin
                s2_res_next.mode_toggle_request = 1'b1;
            end
            else if (press_dur >= {{(TIME_W-MS_W){1'b0}}, press_deb_reg})
            begin
                s2_res_next.reset_request = 1'b1;
            end
        end

        // A new direction is reported once, and only after the debounce gap.
        dir_report = (cur_dir != DIR_IDLE) && (cur_dir != tracked_reg) &&
                     (dir_elapsed >= {{(TIME_W-MS_W){1'b0}}, dir_deb_reg});

        tracked_next          = tracked_reg;
        dir_time_next         = dir_time_reg;
        s2_res_next.direction = DIR_IDLE;
        if (cur_dir == DIR_IDLE)
        begin
            tracked_next = DIR_IDLE;
        end
        else if (dir_report)
        begin
            tracked_next          = cur_dir;
            dir_time_next         = s1_item_reg.now_ms;
            s2_res_next.direction = cur_dir;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            tracked_reg     <= DIR_IDLE;
            dir_time_reg    <= '0;
            held_reg        <= 1'b0;
            press_start_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            if (s1_fire)
            begin
                tracked_reg     <= tracked_next;
                dir_time_reg    <= dir_time_next;
                held_reg        <= held_next;
                press_start_reg <= press_start_next;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.x_sample    <= in_ch.x_sample;
            s1_item_reg.y_sample    <= in_ch.y_sample;
            s1_item_reg.button_down <= in_ch.button_down;
            s1_item_reg.now_ms      <= in_ch.now_ms;
        end
        if (s1_fire)
        begin
            s2_res_reg <= s2_res_next;
        end
    end

    // Configuration writes. Indexes beyond the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_low_reg     <= DZ_LOW_RST;
            dz_high_reg    <= DZ_HIGH_RST;
            center_reg     <= CENTER_RST;
            long_press_reg <= LONG_PRESS_RST;
            press_deb_reg  <= PRESS_DEB_RST;
            dir_deb_reg    <= DIR_DEB_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DZ_LOW:     dz_low_reg     <= cfg_data[SAMPLE_W-1:0];
                REG_DZ_HIGH:    dz_high_reg    <= cfg_data[SAMPLE_W-1:0];
                REG_CENTER:     center_reg     <= cfg_data[SAMPLE_W-1:0];
                REG_LONG_PRESS: long_press_reg <= cfg_data[MS_W-1:0];
                REG_PRESS_DEB:  press_deb_reg  <= cfg_data[MS_W-1:0];
                REG_DIR_DEB:    dir_deb_reg    <= cfg_data[MS_W-1:0];
                default:        ;
            endcase
        end
    end

    assign out_ch.valid               = s2_valid_reg;
    assign out_ch.direction           = s2_res_reg.direction;
    assign out_ch.reset_request       = s2_res_reg.reset_request;
    assign out_ch.mode_toggle_request = s2_res_reg.mode_toggle_request;

endmodule

// File: hw/rtl/jdq_checker.sv
// Port-level checks for the joystick direction qualifier.
// Depends on jdq_pkg; bound to joystick_direction_qualifier_top below.
module jdq_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [jdq_pkg::DIR_W-1:0] out_direction,
    input logic                      out_reset_request,
    input logic                      out_mode_toggle_request
);
    import jdq_pkg::*;

    logic              out_fire;
    logic [DIR_W-1:0]  last_dir_reg;

    assign out_fire = out_valid && out_ready;

    // Direction of the most recently delivered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_dir_reg <= DIR_IDLE;
        end
        else if (out_fire)
        begin
            last_dir_reg <= out_direction;
        end
    end

    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped while stalled");

    a_one_button_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_reset_request && out_mode_toggle_request))
        else $error("release classed as both short and long press");

    a_no_repeat_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && out_direction != DIR_IDLE |-> out_direction != last_dir_reg)
        else $error("same direction reported twice in a row");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while result side is empty");

endmodule

bind joystick_direction_qualifier_top jdq_checker u_jdq_checker (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_ready                (in_ch.ready),
    .out_valid               (out_ch.valid),
    .out_ready               (out_ch.ready),
    .out_direction           (out_ch.direction),
    .out_reset_request       (out_ch.reset_request),
    .out_mode_toggle_request (out_ch.mode_toggle_request)
);
